### hdl/f251_pkg.sv
// Shared types and constants for the sync-framed packet parser.
// No dependencies; used by f251_skid and the top level.
package f251_pkg;

  localparam int unsigned CFG_INDEX_BITS = 1;
  localparam int unsigned CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SYNC_WORD   = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_PAYLOAD = 1'd1;

  localparam logic [8:0] MODULUS        = 9'd251;
  localparam logic [8:0] HEADER_BYTES   = 9'd4;
  localparam logic [8:0] FRAME_OVERHEAD = 9'd6;
  localparam logic [8:0] POS_SYNC_HI    = 9'd0;
  localparam logic [8:0] POS_SYNC_LO    = 9'd1;
  localparam logic [8:0] POS_ID         = 9'd2;
  localparam logic [8:0] POS_LENGTH     = 9'd3;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_position;
    logic       frame_done;
    logic       checksum_ok;
    logic [7:0] frame_id;
    logic [7:0] frame_length;
  } res_t;

endpackage

### hdl/f251_skid.sv
// Two-entry output buffer for parser results: an output register and a skid register.
// Depends on f251_pkg (res_t).
module f251_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  f251_pkg::res_t push_data,
  output logic          push_stall,
  output logic          pop_valid,
  output f251_pkg::res_t pop_data,
  input  logic          pop_stall
);

  logic           main_valid;
  f251_pkg::res_t main_data;
  logic           skid_valid;
  f251_pkg::res_t skid_data;
  logic           push;
  logic           pop;

  assign push_stall = skid_valid;
  assign push       = push_valid && !skid_valid;
  assign pop        = main_valid && !pop_stall;
  assign pop_valid  = main_valid;
  assign pop_data   = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        main_data <= push_data;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data  <= push_data;
        main_valid <= 1'b1;
      end else begin
        // output stalled: park the item
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid holds an item while the output register is empty");
`endif

endmodule

### hdl/fletcher251_packet_parser_unit.sv
// Sync-framed packet parser with a Fletcher-style check modulo 251.
// Depends on f251_pkg and f251_skid.
//
// One received byte is taken per clock cycle while in_stall is low; each gives one result in the output buffer.
// All the work for a byte (sync compare, two modulo-251 adds, position step) sits
// between the input and the result register. A two-entry output buffer lets one
// more byte in while a result waits; in_stall rises only when both entries are full.
module fletcher251_packet_parser_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [f251_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [f251_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                payload_valid,
  output logic [7:0]                          payload_byte,
  output logic [7:0]                          payload_position,
  output logic                                frame_done,
  output logic                                checksum_ok,
  output logic [7:0]                          frame_id,
  output logic [7:0]                          frame_length
);

  logic [15:0] sync_word;
  logic [7:0]  max_payload_length;

  logic [8:0] byte_position, byte_position_next;
  logic [7:0] held_id, held_id_next;
  logic [7:0] held_length, held_length_next;
  logic [7:0] sum_first, sum_first_next;
  logic [7:0] sum_second, sum_second_next;
  logic [7:0] first_check_byte, first_check_byte_next;

  logic           accept;
  f251_pkg::res_t res;
  f251_pkg::res_t out_res;

  logic [8:0] len9;
  logic [7:0] b_red;
  logic [8:0] s1_raw, s2_raw, init_raw;
  logic [7:0] s1_mod, s2_mod, init_mod;
  logic       in_sum;

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word          <= 16'd0;
      max_payload_length <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        f251_pkg::CFG_SYNC_WORD:   sync_word          <= cfg_data;
        f251_pkg::CFG_MAX_PAYLOAD: max_payload_length <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // modulo-251 arithmetic; sums always stay below 251
  always_comb begin
    len9     = {1'b0, held_length};
    b_red    = (rx_byte >= f251_pkg::MODULUS[7:0]) ? rx_byte - f251_pkg::MODULUS[7:0]
                                                   : rx_byte;
    s1_raw   = {1'b0, sum_first} + {1'b0, b_red};
    s1_mod   = (s1_raw >= f251_pkg::MODULUS) ? 8'(s1_raw - f251_pkg::MODULUS) : s1_raw[7:0];
    s2_raw   = {1'b0, sum_second} + {1'b0, s1_mod};
    s2_mod   = (s2_raw >= f251_pkg::MODULUS) ? 8'(s2_raw - f251_pkg::MODULUS) : s2_raw[7:0];
    init_raw = {1'b0, rx_byte} + 9'd1;
    init_mod = (init_raw >= f251_pkg::MODULUS) ? 8'(init_raw - f251_pkg::MODULUS)
                                               : init_raw[7:0];
    in_sum   = (byte_position != f251_pkg::POS_SYNC_HI) &&
               (byte_position < len9 + f251_pkg::HEADER_BYTES);
  end

  always_comb begin
    byte_position_next    = byte_position;
    held_id_next          = held_id;
    held_length_next      = held_length;
    sum_first_next        = sum_first;
    sum_second_next       = sum_second;
    first_check_byte_next = first_check_byte;
    res                   = '0;

    if (in_sum) begin
      sum_first_next  = s1_mod;
      sum_second_next = s2_mod;
    end

    if (byte_position == f251_pkg::POS_SYNC_HI) begin
      if (rx_byte == sync_word[15:8]) begin
        sum_first_next     = init_mod;
        sum_second_next    = init_mod;
        byte_position_next = f251_pkg::POS_SYNC_LO;
      end
    end else if (byte_position == f251_pkg::POS_SYNC_LO) begin
      // a mismatch restarts the hunt without rechecking this byte
      byte_position_next = (rx_byte == sync_word[7:0]) ? f251_pkg::POS_ID
                                                        : f251_pkg::POS_SYNC_HI;
    end else if (byte_position == f251_pkg::POS_ID) begin
      held_id_next       = rx_byte;
      byte_position_next = f251_pkg::POS_LENGTH;
    end else if (byte_position == f251_pkg::POS_LENGTH) begin
      if (rx_byte <= max_payload_length) begin
        held_length_next   = rx_byte;
        byte_position_next = f251_pkg::HEADER_BYTES;
      end else begin
        byte_position_next = f251_pkg::POS_SYNC_HI;
      end
    end else if (byte_position < len9 + f251_pkg::FRAME_OVERHEAD) begin
      if (in_sum) begin
        res.payload_valid    = 1'b1;
        res.payload_byte     = rx_byte;
        res.payload_position = 8'(byte_position - f251_pkg::HEADER_BYTES);
        byte_position_next   = byte_position + 9'd1;
      end else if (byte_position == len9 + f251_pkg::HEADER_BYTES) begin
        first_check_byte_next = rx_byte;
        byte_position_next    = byte_position + 9'd1;
      end else begin
        res.frame_done     = 1'b1;
        res.checksum_ok    = (first_check_byte == sum_first) && (rx_byte == sum_second);
        byte_position_next = f251_pkg::POS_SYNC_HI;
      end
    end else begin
      // past the frame end: drop the byte and hunt again
      byte_position_next = f251_pkg::POS_SYNC_HI;
    end

    res.frame_id     = held_id_next;
    res.frame_length = held_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 9'd0;
      held_id       <= 8'd0;
      held_length   <= 8'd0;
      sum_first     <= 8'd0;
      sum_second    <= 8'd0;
    end else if (accept) begin
      byte_position <= byte_position_next;
      held_id       <= held_id_next;
      held_length   <= held_length_next;
      sum_first     <= sum_first_next;
      sum_second    <= sum_second_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_check_byte <= first_check_byte_next;
    end
  end

  f251_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_data  (res),
    .push_stall (in_stall),
    .pop_valid  (out_valid),
    .pop_data   (out_res),
    .pop_stall  (out_stall)
  );

  assign payload_valid    = out_res.payload_valid;
  assign payload_byte     = out_res.payload_byte;
  assign payload_position = out_res.payload_position;
  assign frame_done       = out_res.frame_done;
  assign checksum_ok      = out_res.checksum_ok;
  assign frame_id         = out_res.frame_id;
  assign frame_length     = out_res.frame_length;

`ifndef NO_ASSERTIONS
  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    byte_position <= {1'b0, held_length} + 9'd5)
    else $error("byte position beyond the frame end");

  a_sums_reduced: assert property (@(posedge clk) disable iff (rst)
    (sum_first < f251_pkg::MODULUS[7:0]) && (sum_second < f251_pkg::MODULUS[7:0]))
    else $error("running sums not reduced modulo 251");

  a_done_xor_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(payload_valid && frame_done))
    else $error("result flags both a payload byte and frame end");

  a_ok_needs_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && checksum_ok) |-> frame_done)
    else $error("checksum_ok raised outside frame end");

  a_done_restarts_hunt: assert property (@(posedge clk) disable iff (rst)
    (accept && res.frame_done) |=> (byte_position == f251_pkg::POS_SYNC_HI))
    else $error("hunt did not restart after frame end");
`endif

endmodule
